// ===== rtl/qrs_pkg.sv =====
// qrs_pkg: status codes and flag bundle shared by the quadratic root solver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

  typedef enum logic [1:0] {
    ST_REAL    = 2'd0,
    ST_COMPLEX = 2'd1,
    ST_NOSOL   = 2'd2,
    ST_SAT     = 2'd3
  } status_e;

  // case flags that ride along the divider pipeline
  typedef struct packed {
    logic nosol;
    logic lin;
    logic dneg;
  } qrs_flags_t;

endpackage

`default_nettype wire

// ===== rtl/qrs_disc.sv =====
// qrs_disc: two-stage discriminant b*b - 4ac, magnitude and sign
// standalone, no package use
`timescale 1ns / 1ps
`default_nettype none

module qrs_disc #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic signed [W-1:0] c_i,
  input  logic signed [W-1:0] ci_i,
  output logic                valid_o,
  output logic [2*W+1:0]      d_o,
  output logic                dneg_o,
  output logic signed [W-1:0] a_o,
  output logic signed [W-1:0] b_o,
  output logic signed [W-1:0] c_o,
  output logic signed [W-1:0] ci_o
);

  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 2;

  logic [W-1:0]  ma, mb, mc;
  logic          v1_q, v2_q;
  logic [PW-1:0] pb_q, pac_q;
  logic          sd_q;
  logic signed [W-1:0] a1_q, b1_q, c1_q, ci1_q;
  logic signed [W-1:0] a2_q, b2_q, c2_q, ci2_q;
  logic [DW-1:0] pbx, q4, d_d, d_q;
  logic          dneg_d, dneg_q;

  // magnitudes as unsigned, the most negative value maps to 2^(W-1)
  assign ma = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign mb = b_i[W-1] ? (~b_i + 1'b1) : b_i;
  assign mc = c_i[W-1] ? (~c_i + 1'b1) : c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage 1: the two products
  always_ff @(posedge clk_i) begin
    pb_q  <= PW'(mb) * PW'(mb);
    pac_q <= PW'(ma) * PW'(mc);
    sd_q  <= (c_i != '0) && (a_i[W-1] != c_i[W-1]);
    a1_q  <= a_i;
    b1_q  <= b_i;
    c1_q  <= c_i;
    ci1_q <= ci_i;
  end

  // stage 2: combine, -4ac adds when a and c differ in sign
  always_comb begin
    pbx    = {2'b00, pb_q};
    q4     = {pac_q, 2'b00};
    dneg_d = 1'b0;
    if (sd_q) begin
      d_d = pbx + q4;
    end else if (pbx >= q4) begin
      d_d = pbx - q4;
    end else begin
      d_d    = q4 - pbx;
      dneg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    dneg_q <= dneg_d;
    a2_q   <= a1_q;
    b2_q   <= b1_q;
    c2_q   <= c1_q;
    ci2_q  <= ci1_q;
  end

  assign valid_o = v2_q;
  assign d_o     = d_q;
  assign dneg_o  = dneg_q;
  assign a_o     = a2_q;
  assign b_o     = b2_q;
  assign c_o     = c2_q;
  assign ci_o    = ci2_q;

endmodule

`default_nettype wire

// ===== rtl/qrs_sqrt.sv =====
// qrs_sqrt: pipelined integer floor square root, one root bit per stage
// standalone, no package use
`timescale 1ns / 1ps
`default_nettype none

module qrs_sqrt #(
  parameter int DW = 66,
  parameter int SW = 129
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [DW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [DW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int RW = DW / 2;

  logic            valid_q [RW];
  logic [DW-1:0]   rad_q   [RW];
  logic [RW+1:0]   rem_q   [RW];
  logic [RW-1:0]   root_q  [RW];
  logic [SW-1:0]   side_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic          vin;
    logic [DW-1:0] rin;
    logic [RW+1:0] min;
    logic [RW-1:0] oin;
    logic [SW-1:0] sin;
    logic [RW+1:0] sh, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign rin = rad_i;
      assign min = '0;
      assign oin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign vin = valid_q[k-1];
      assign rin = rad_q[k-1];
      assign min = rem_q[k-1];
      assign oin = root_q[k-1];
      assign sin = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      sh    = {min[RW-1:0], rin[DW-1:DW-2]};
      trial = {oin, 2'b01};
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rin << 2;
      rem_q[k]  <= ge ? (sh - trial) : sh;
      root_q[k] <= {oin[RW-2:0], ge};
      side_q[k] <= sin;
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

`default_nettype wire

// ===== rtl/qrs_div.sv =====
// qrs_div: two-lane pipelined restoring divider, (num << F) / den, one bit per stage
// standalone, no package use
`timescale 1ns / 1ps
`default_nettype none

module qrs_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SW = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [1:0][W+1:0]    num_i,
  input  logic [W:0]           den_i,
  input  logic [1:0]           neg_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [1:0][W-1:0]    quo_o,
  output logic [1:0]           ovf_o,
  output logic [1:0]           neg_o,
  output logic [SW-1:0]        side_o
);

  localparam int MW  = W + 2;
  localparam int DDW = W + 1;
  localparam int LW  = MW + F;

  logic                    valid_q [LW];
  logic [1:0][LW-1:0]      dvd_q   [LW];
  logic [1:0][DDW-1:0]     rem_q   [LW];
  logic [1:0][W-1:0]       quo_q   [LW];
  logic [1:0]              ovf_q   [LW];
  logic [DDW-1:0]          den_q   [LW];
  logic [1:0]              neg_q   [LW];
  logic [SW-1:0]           side_q  [LW];

  for (genvar k = 0; k < LW; k++) begin : g_stage
    logic               vin;
    logic [1:0][LW-1:0] din;
    logic [1:0][DDW-1:0] rin;
    logic [1:0][W-1:0]  qin;
    logic [1:0]         oin;
    logic [DDW-1:0]     nin;
    logic [1:0]         gin;
    logic [SW-1:0]      sin;
    logic [1:0][DDW:0]  sh;
    logic [1:0]         ge;
    logic [1:0][DDW-1:0] rem_d;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign din = {{num_i[1], F'(0)}, {num_i[0], F'(0)}};
      assign rin = '0;
      assign qin = '0;
      assign oin = '0;
      assign nin = den_i;
      assign gin = neg_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = valid_q[k-1];
      assign din = dvd_q[k-1];
      assign rin = rem_q[k-1];
      assign qin = quo_q[k-1];
      assign oin = ovf_q[k-1];
      assign nin = den_q[k-1];
      assign gin = neg_q[k-1];
      assign sin = side_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sh[l]    = {rin[l], din[l][LW-1]};
        ge[l]    = (sh[l] >= {1'b0, nin});
        rem_d[l] = ge[l] ? DDW'(sh[l] - {1'b0, nin}) : sh[l][DDW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vin;
      end
    end

    // quotient bits above W-1 only matter as an overflow mark
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 2; l++) begin
        dvd_q[k][l] <= din[l] << 1;
        rem_q[k][l] <= rem_d[l];
        quo_q[k][l] <= {qin[l][W-2:0], ge[l]};
        ovf_q[k][l] <= oin[l] | qin[l][W-1];
      end
      den_q[k]  <= nin;
      neg_q[k]  <= gin;
      side_q[k] <= sin;
    end
  end

  assign valid_o = valid_q[LW-1];
  assign quo_o   = quo_q[LW-1];
  assign ovf_o   = ovf_q[LW-1];
  assign neg_o   = neg_q[LW-1];
  assign side_o  = side_q[LW-1];

endmodule

`default_nettype wire

// ===== rtl/quadratic_root_solver.sv =====
// quadratic_root_solver: top level, discriminant, square root, divide, saturate
// depends on qrs_pkg, qrs_disc, qrs_sqrt, qrs_div
//
//   channel   signals                                         dir  handshake
//   command   start_i, coef_quad_i, coef_lin_i,               in   start_i && !busy_o
//             coef_const_i, coef_const_imag_i
//   result    done_o, root_real_o, root_imag_o, status_o      out  done_o strobe, one cycle
//
// the pipeline has two discriminant stages, COEF_WIDTH+1 square-root stages, one operand
// select stage, COEF_WIDTH+2+FRAC_BITS divider stages and the output register; the
// bit-serial root and divide chains make up most of its depth
// one beat per cycle is taken; busy_o stays low since every stage advances each cycle
// reset clears only the valid bits; payload registers are not reset
// the receiver cannot stall, so each result is shown for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COEF_WIDTH-1:0] coef_quad_i,
  input  logic signed [COEF_WIDTH-1:0] coef_lin_i,
  input  logic signed [COEF_WIDTH-1:0] coef_const_i,
  input  logic signed [COEF_WIDTH-1:0] coef_const_imag_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic signed [COEF_WIDTH-1:0] root_real_o,
  output logic signed [COEF_WIDTH-1:0] root_imag_o,
  output logic [1:0]                   status_o
);

  localparam int W   = COEF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * W + 2;  // discriminant magnitude
  localparam int RW  = W + 1;      // square root
  localparam int NW  = W + 3;      // signed numerator
  localparam int MW  = W + 2;      // numerator magnitude
  localparam int DDW = W + 1;      // denominator magnitude
  localparam int SW  = 4 * W + 1;  // coefficients plus sign of discriminant
  localparam int FW  = $bits(qrs_flags_t);

  // pipeline never holds back a beat
  assign busy_o = 1'b0;

  // discriminant
  logic                dc_valid;
  logic [DW-1:0]       dc_d;
  logic                dc_dneg;
  logic signed [W-1:0] dc_a, dc_b, dc_c, dc_ci;

  qrs_disc #(.W(W)) u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .a_i     (coef_quad_i),
    .b_i     (coef_lin_i),
    .c_i     (coef_const_i),
    .ci_i    (coef_const_imag_i),
    .valid_o (dc_valid),
    .d_o     (dc_d),
    .dneg_o  (dc_dneg),
    .a_o     (dc_a),
    .b_o     (dc_b),
    .c_o     (dc_c),
    .ci_o    (dc_ci)
  );

  // square root, coefficients ride along as side data
  logic          sq_valid;
  logic [RW-1:0] sq_root;
  logic [SW-1:0] sq_side;

  qrs_sqrt #(.DW(DW), .SW(SW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dc_valid),
    .rad_i   (dc_d),
    .side_i  ({dc_a, dc_b, dc_c, dc_ci, dc_dneg}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // operand select: pick numerators and denominator for the case at hand
  logic signed [W-1:0]  sa, sb, sc, sci;
  logic                 sdneg;
  logic                 lin, nosol;
  logic signed [NW-1:0] nb, sx, nre, nim, are, aim;
  logic signed [W+1:0]  den, aden;
  qrs_flags_t           flg_d;

  assign {sa, sb, sc, sci, sdneg} = sq_side;

  always_comb begin
    lin   = (sa == '0);
    nosol = lin && (sb == '0);
    nb    = -NW'(sb);
    sx    = NW'(sq_root);
    if (lin) begin
      // linear root -c/b and -ci/b
      nre = -NW'(sc);
      nim = -NW'(sci);
      den = (W + 2)'(sb);
    end else begin
      // (-b + sqrt(d)) / 2a, or -b/2a with sqrt(-d)/2a when d is negative
      nre = sdneg ? nb : (nb + sx);
      nim = sdneg ? sx : '0;
      den = (W + 2)'(sa) <<< 1;
    end
    are        = nre[NW-1] ? -nre : nre;
    aim        = nim[NW-1] ? -nim : nim;
    aden       = den[W+1] ? -den : den;
    flg_d.nosol = nosol;
    flg_d.lin   = lin;
    flg_d.dneg  = sdneg;
  end

  logic                sel_valid_q;
  logic [1:0][MW-1:0]  sel_num_q;
  logic [DDW-1:0]      sel_den_q;
  logic [1:0]          sel_neg_q;
  qrs_flags_t          sel_flg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
    end else begin
      sel_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_num_q[0] <= are[MW-1:0];
    sel_num_q[1] <= aim[MW-1:0];
    sel_den_q    <= aden[DDW-1:0];
    sel_neg_q[0] <= nre[NW-1] ^ den[W+1];
    sel_neg_q[1] <= nim[NW-1] ^ den[W+1];
    sel_flg_q    <= flg_d;
  end

  // divider, real part in lane 0 and imaginary part in lane 1
  logic              dv_valid;
  logic [1:0][W-1:0] dv_quo;
  logic [1:0]        dv_ovf;
  logic [1:0]        dv_neg;
  logic [FW-1:0]     dv_side;
  qrs_flags_t        dv_flg;

  qrs_div #(.W(W), .F(F), .SW(FW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid_q),
    .num_i   (sel_num_q),
    .den_i   (sel_den_q),
    .neg_i   (sel_neg_q),
    .side_i  (sel_flg_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .neg_o   (dv_neg),
    .side_o  (dv_side)
  );

  assign dv_flg = qrs_flags_t'(dv_side);

  // sign, saturation and status
  logic [1:0][W-1:0] val;
  logic [1:0]        sat;
  status_e           st_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dv_neg[l]) begin
        // negative limit is reachable exactly, one past it clamps
        sat[l] = dv_ovf[l] | (dv_quo[l][W-1] & (|dv_quo[l][W-2:0]));
        val[l] = sat[l] ? {1'b1, {(W-1){1'b0}}} : (~dv_quo[l] + 1'b1);
      end else begin
        sat[l] = dv_ovf[l] | dv_quo[l][W-1];
        val[l] = sat[l] ? {1'b0, {(W-1){1'b1}}} : dv_quo[l];
      end
    end
    if (dv_flg.nosol) begin
      st_d = ST_NOSOL;
    end else if (|sat) begin
      st_d = ST_SAT;
    end else if (dv_flg.lin) begin
      st_d = (val[1] != '0) ? ST_COMPLEX : ST_REAL;
    end else begin
      st_d = dv_flg.dneg ? ST_COMPLEX : ST_REAL;
    end
  end

  logic                done_q;
  logic signed [W-1:0] root_real_q, root_imag_q;
  status_e             status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    root_real_q <= dv_flg.nosol ? '0 : val[0];
    root_imag_q <= dv_flg.nosol ? '0 : val[1];
    status_q    <= st_d;
  end

  assign done_o      = done_q;
  assign root_real_o = root_real_q;
  assign root_imag_o = root_imag_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== rtl/qrs_chk.sv =====
// qrs_chk: port-level checks for quadratic_root_solver, bound to the top level
// depends on qrs_pkg
`timescale 1ns / 1ps
`default_nettype none

module qrs_chk
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  done_o,
  input logic [COEF_WIDTH-1:0] root_real_o,
  input logic [COEF_WIDTH-1:0] root_imag_o,
  input logic [1:0]            status_o
);

  localparam int LAT = 2 * COEF_WIDTH + FRAC_BITS + 7;

  // a result beat only ever follows an accepted command beat
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result beat without matching command beat");

  a_nosol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_NOSOL) |-> (root_real_o == '0 && root_imag_o == '0))
    else $error("no-solution result carries a nonzero root");

  a_real_no_imag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_REAL) |-> (root_imag_o == '0))
    else $error("real root with nonzero imaginary part");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("pipeline held back a command beat");

endmodule

bind quadratic_root_solver qrs_chk #(
  .COEF_WIDTH (COEF_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_qrs_chk (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for quadratic_root_solver
// depends on qrs_pkg and the quadratic_root_solver rtl; predicts each root in place
`timescale 1ns / 1ps
`default_nettype none

module tb
  import qrs_pkg::*;
();

  localparam int CW        = 32;
  localparam int FB        = 16;
  localparam int LATENCY   = 2 * CW + FB + 7;
  localparam int N_RANDOM  = 1300;
  localparam int MAX_CYCLE = 400000;
  localparam logic signed [CW-1:0] MAXV = 32'sh7fffffff;
  localparam logic signed [CW-1:0] MINV = 32'sh80000000;
  localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] re;
    logic signed [CW-1:0] im;
    status_e              st;
  } root_t;

  // one row of the directed table; known marks a typed-in expected root
  typedef struct {
    logic signed [CW-1:0] a, b, c, ci;
    bit                   known;
    root_t                root;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic signed [CW-1:0] coef_quad_i, coef_lin_i, coef_const_i, coef_const_imag_i;
  logic                 busy_o, done_o;
  logic signed [CW-1:0] root_real_o, root_imag_o;
  logic [1:0]           status_o;

  // typed-in expectation riding along with the driven beat
  bit    drv_known;
  root_t drv_root;

  root_t roots_pending[$];
  int    n_errors;
  int    n_cycles;
  row_t  rows[$];

  quadratic_root_solver u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .coef_quad_i      (coef_quad_i),
    .coef_lin_i       (coef_lin_i),
    .coef_const_i     (coef_const_i),
    .coef_const_imag_i(coef_const_imag_i),
    .busy_o           (busy_o),
    .done_o           (done_o),
    .root_real_o      (root_real_o),
    .root_imag_o      (root_imag_o),
    .status_o         (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic wide_t abs_wide(input wide_t v);
    return v < 0 ? -v : v;
  endfunction

  // floor square root of a nonnegative value below 2^127
  function automatic wide_t floor_sqrt(input wide_t n);
    logic [127:0] r, cand;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      cand = r | (128'd1 << k);
      if (cand * cand <= n) r = cand;
    end
    return r;
  endfunction

  // (num * 2^FB) / den, truncated toward zero, clamped to the port range
  function automatic logic signed [CW-1:0] fix_div(input wide_t num, input wide_t den,
                                                    output bit clamped);
    bit           neg;
    logic [127:0] quo, lim;
    neg     = (num < 0) != (den < 0);
    lim     = 128'd1 << (CW - 1);
    quo     = (abs_wide(num) << FB) / abs_wide(den);
    clamped = 1'b0;
    if (neg) begin
      if (quo > lim) begin
        clamped = 1'b1;
        return MINV;
      end
      return -quo[CW-1:0];
    end
    if (quo >= lim) begin
      clamped = 1'b1;
      return MAXV;
    end
    return quo[CW-1:0];
  endfunction

  function automatic root_t solve_root(input logic signed [CW-1:0] a, b, c, ci);
    root_t r;
    wide_t aw, bw, cw, disc, sq;
    bit    s0, s1;
    aw   = wide_t'(a);
    bw   = wide_t'(b);
    cw   = wide_t'(c);
    r.re = '0;
    r.im = '0;
    r.st = ST_REAL;
    s0   = 1'b0;
    s1   = 1'b0;
    if (a == 0) begin
      if (b == 0) begin
        r.st = ST_NOSOL;
      end else begin
        // linear root, the imaginary constant only matters here
        r.re = fix_div(-cw, bw, s0);
        r.im = fix_div(-wide_t'(ci), bw, s1);
        r.st = (r.im != 0) ? ST_COMPLEX : ST_REAL;
      end
    end else begin
      disc = bw * bw - 4 * aw * cw;
      sq   = floor_sqrt(abs_wide(disc));
      if (disc < 0) begin
        // conjugate pair; imaginary part follows the sign of a
        r.re = fix_div(-bw, 2 * aw, s0);
        r.im = fix_div(sq, 2 * aw, s1);
        r.st = ST_COMPLEX;
      end else begin
        r.re = fix_div(-bw + sq, 2 * aw, s0);
      end
    end
    if (s0 || s1) r.st = ST_SAT;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic signed [CW-1:0] got,
                                 input logic signed [CW-1:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, n_cycles);
    n_errors++;
  endtask

  // sample before any update of this edge: results first, then the accepted beat
  always @(posedge clk_i) begin
    root_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (roots_pending.size() == 0) begin
          $display("unexpected result beat at cycle %0d", n_cycles);
          n_errors++;
        end else begin
          want = roots_pending.pop_front();
          if (root_real_o !== want.re) report_mismatch("root_real", root_real_o, want.re);
          if (root_imag_o !== want.im) report_mismatch("root_imag", root_imag_o, want.im);
          if (status_o !== want.st) report_mismatch("status", CW'(status_o), CW'(want.st));
        end
      end
      if (start_i && !busy_o) begin
        if (drv_known) roots_pending.push_back(drv_root);
        else roots_pending.push_back(solve_root(coef_quad_i, coef_lin_i, coef_const_i,
                                                coef_const_imag_i));
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= MAX_CYCLE) begin
      $display("** quadratic_root_solver: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic row_t make_row(input logic signed [CW-1:0] a, b, c, ci);
    row_t r;
    r.a     = a;
    r.b     = b;
    r.c     = c;
    r.ci    = ci;
    r.known = 1'b0;
    r.root  = '{re: '0, im: '0, st: ST_REAL};
    return r;
  endfunction

  function automatic row_t known_row(input logic signed [CW-1:0] a, b, c, ci, re, im,
                                     input status_e st);
    row_t r;
    r       = make_row(a, b, c, ci);
    r.known = 1'b1;
    r.root  = '{re: re, im: im, st: st};
    return r;
  endfunction

  // mostly modest magnitudes so roots land in range, plus full-width noise
  function automatic logic signed [CW-1:0] draw_coef();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return $urandom;
      3:       return $urandom_range(0, 1) ? MAXV : MINV;
      4:       return $signed($urandom_range(0, 255)) - 128;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  task automatic send_beat(input row_t r);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i           <= 1'b1;
    coef_quad_i       <= r.a;
    coef_lin_i        <= r.b;
    coef_const_i      <= r.c;
    coef_const_imag_i <= r.ci;
    drv_known         <= r.known;
    drv_root          <= r.root;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    row_t r;
    int   waited;
    n_errors          = 0;
    n_cycles          = 0;
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    coef_quad_i       = '0;
    coef_lin_i        = '0;
    coef_const_i      = '0;
    coef_const_imag_i = '0;
    drv_known         = 1'b0;
    drv_root          = '{re: '0, im: '0, st: ST_REAL};

    // directed table: no solution, linear, each discriminant sign, clamping, extremes
    rows.push_back(known_row(0, 0, 5 * ONE, ONE, 0, 0, ST_NOSOL));
    rows.push_back(known_row(0, 0, MINV, MAXV, 0, 0, ST_NOSOL));
    rows.push_back(known_row(0, ONE, -2 * ONE, 0, 2 * ONE, 0, ST_REAL));
    rows.push_back(known_row(0, ONE, 0, -3 * ONE, 0, 3 * ONE, ST_COMPLEX));
    rows.push_back(known_row(0, 1, MINV, 0, MAXV, 0, ST_SAT));
    rows.push_back(known_row(0, 1, MAXV, 0, MINV, 0, ST_SAT));
    rows.push_back(known_row(ONE, 0, -4 * ONE, 0, 2 * ONE, 0, ST_REAL));
    rows.push_back(known_row(ONE, 0, 4 * ONE, 0, 0, 2 * ONE, ST_COMPLEX));
    rows.push_back(known_row(-ONE, 0, -4 * ONE, 0, 0, -2 * ONE, ST_COMPLEX));
    rows.push_back(known_row(ONE, 2 * ONE, ONE, 0, -ONE, 0, ST_REAL));
    rows.push_back(make_row(0, MINV, MAXV, MINV));
    rows.push_back(make_row(0, MAXV, MINV, MAXV));
    rows.push_back(make_row(0, -1, 1, -1));
    rows.push_back(make_row(MAXV, MAXV, MAXV, MAXV));
    rows.push_back(make_row(MINV, MINV, MINV, MINV));
    rows.push_back(make_row(MINV, MAXV, MAXV, 0));
    rows.push_back(make_row(MAXV, MINV, MINV, -1));
    rows.push_back(make_row(1, MAXV, 0, 0));
    rows.push_back(make_row(1, MINV, 1, 0));
    rows.push_back(make_row(-1, 0, MAXV, 0));
    rows.push_back(make_row(1, 1, 1, 1));
    rows.push_back(make_row(-1, -1, -1, -1));
    rows.push_back(make_row(3 * ONE, -5 * ONE, ONE / 2, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) send_beat(rows[k]);
    for (int k = 0; k < N_RANDOM; k++) begin
      r = make_row(draw_coef(), draw_coef(), draw_coef(), draw_coef());
      // some degenerate shapes: linear (a = 0), and b = 0, which with a = 0 has no solution
      if ($urandom_range(0, 7) == 0) r.a = '0;
      if ($urandom_range(0, 31) == 0) r.b = '0;
      send_beat(r);
    end
    start_i <= 1'b0;

    // drain, then wait on for stray beats
    waited = 0;
    while (roots_pending.size() != 0 && waited < 4 * LATENCY) begin
      @(posedge clk_i);
      waited++;
    end
    if (roots_pending.size() != 0) begin
      $display("%0d roots never arrived", roots_pending.size());
      n_errors++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0) $display("** quadratic_root_solver: PASSED **");
    else $display("** quadratic_root_solver: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/qrs_pkg.sv
rtl/qrs_disc.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
rtl/qrs_chk.sv
tb/sv/tb.sv
